FILE: sv/clipped_normalized_lms_filter_assert.svh
`ifndef CLIPPED_NORMALIZED_LMS_FILTER_ASSERT_SVH
`define CLIPPED_NORMALIZED_LMS_FILTER_ASSERT_SVH

// same-cycle implication
`define CNLMS_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cnlms assertion failed");

// next-cycle implication
`define CNLMS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cnlms assertion failed");

`endif

FILE: sv/cnlms_pkg.sv
package cnlms_pkg;

   typedef logic signed [15:0] sample_type;
   typedef logic        [15:0] step_type;
   typedef logic signed [23:0] coef_type;

   localparam int ACC_W  = 48;
   localparam int PROD_W = 50;
   localparam int SQ_W   = 40;
   localparam int DEN_W  = 32;
   localparam int Q_W    = 17;

   localparam logic [Q_W-1:0]  CLIP_Q20   = 17'd104858;
   localparam logic [SQ_W-1:0] SQ_BIT0    = 40'h40_0000_0000;
   localparam logic [19:0]     NORM_UNITY = 20'd32768;
   localparam step_type        STEP_RESET = 16'd1311;

endpackage

FILE: sv/clipped_normalized_lms_filter.sv
// normalized lms adaptive fir filter, clipped coefficient update
// req channel: one item carries a desired and a reference sample; it is
//   taken when req_valid is high and req_stall is low
// rsp channel: one error_sample item per request, held while rsp_stall is high
// csr channel: step_size write, taken when csr_valid and csr_ready are high
// the error item is issued after the filter pass over all taps
// one item is processed at a time, paced by the single shared
//   33x17 multiplier (three uses per tap), a 20-step square root once per
//   item and a 17-step divider per tap (skipped on overflow) in the update
// req_stall stays high while an item is being processed
// if the error of a new item is ready while the previous error is still
//   stalled, the block waits until the previous item is taken
// reset: synchronous; a clearing pass over all TAPS entries zeroes the delay line
//   and coefficients, then req_stall drops; step_size returns to 1311
module clipped_normalized_lms_filter #(
   parameter int TAPS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cnlms_pkg::sample_type req_desired_sample,
   input  cnlms_pkg::sample_type req_reference_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cnlms_pkg::sample_type rsp_error_sample,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  cnlms_pkg::step_type   csr_step_size
);
   import cnlms_pkg::*;

   localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   localparam logic [3:0] ST_CLR  = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_RD   = 4'd2;
   localparam logic [3:0] ST_M1   = 4'd3;
   localparam logic [3:0] ST_M2   = 4'd4;
   localparam logic [3:0] ST_M3   = 4'd5;
   localparam logic [3:0] ST_ERR  = 4'd6;
   localparam logic [3:0] ST_SQRT = 4'd7;
   localparam logic [3:0] ST_SE   = 4'd8;
   localparam logic [3:0] ST_SE2  = 4'd9;
   localparam logic [3:0] ST_URD  = 4'd10;
   localparam logic [3:0] ST_UM   = 4'd11;
   localparam logic [3:0] ST_UCMP = 4'd12;
   localparam logic [3:0] ST_UDIV = 4'd13;
   localparam logic [3:0] ST_UAPP = 4'd14;

   sample_type dl_mem   [TAPS];
   coef_type   coef_mem [TAPS];

   logic [3:0]              state_ff, state_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        wptr_ff, wptr_in;
   logic [IDX_W-1:0]        base_ff, base_in;
   step_type                step_ff, step_in;
   sample_type              des_ff, des_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [SQ_W-1:0]         sumsq_ff, sumsq_in;
   logic signed [PROD_W-1:0] prod_ff;
   sample_type              err_ff, err_in;
   logic [SQ_W-1:0]         v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic signed [32:0]      se_ff, se_in;
   logic                    neg_ff, neg_in, ovf_ff, ovf_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [Q_W-1:0]          qn_ff, qn_in;
   logic [4:0]              dcnt_ff, dcnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sample_type              rsp_data_ff, rsp_data_in;
   sample_type              dl_q_ff;
   coef_type                coef_q_ff;

   logic                     accept, rd_en, clearing, last;
   logic                     dl_we, coef_we;
   logic [IDX_W-1:0]         dl_wa, rd_phys;
   sample_type               dl_wd;
   coef_type                 coef_wd;
   logic [IDX_W:0]           psum, pwrap;
   logic signed [32:0]       mul_a;
   logic signed [16:0]       mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [16:0]       dl_ext, dl_abs;
   logic signed [32:0]       se_abs;
   logic signed [PROD_W-1:0] efull;
   logic signed [29:0]       er;
   logic [SQ_W-1:0]          sq_trial;
   logic [19:0]              norm;
   logic [47:0]              nmag;
   logic [DEN_W-1:0]         trial;
   logic [Q_W-1:0]           umag;
   logic signed [25:0]       delta, csum;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_error_sample = rsp_data_ff;

   assign clearing = (state_ff == ST_CLR);
   assign last     = (cnt_ff == IDX_W'(TAPS - 1));
   assign rd_en    = (state_ff == ST_RD) || (state_ff == ST_URD);
   assign psum     = {1'b0, base_ff} + {1'b0, cnt_ff};
   assign pwrap    = psum - (IDX_W + 1)'(TAPS);
   assign rd_phys  = (psum >= (IDX_W + 1)'(TAPS)) ? pwrap[IDX_W-1:0] : psum[IDX_W-1:0];

   assign dl_we = clearing || accept;
   assign dl_wa = clearing ? cnt_ff : wptr_ff;
   assign dl_wd = clearing ? '0 : req_reference_sample;

   assign dl_ext = 17'(dl_q_ff);
   assign dl_abs = dl_ext[16] ? -dl_ext : dl_ext;
   assign se_abs = se_ff[32] ? -se_ff : se_ff;

   always_comb begin
      unique case (state_ff)
         ST_M1: begin
            mul_a = 33'(coef_q_ff);
            mul_b = dl_ext;
         end
         ST_M2: begin
            mul_a = 33'(dl_q_ff);
            mul_b = dl_ext;
         end
         ST_SE: begin
            mul_a = {17'b0, step_ff};
            mul_b = 17'(err_ff);
         end
         default: begin
            mul_a = se_abs;
            mul_b = dl_abs;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign efull = {{(PROD_W - 36){des_ff[15]}}, des_ff, 20'b0}
                - PROD_W'(acc_ff) + PROD_W'(524288);
   assign er    = efull[49:20];

   assign sq_trial = res_ff + bit_ff;
   assign norm     = (sumsq_ff == '0) ? NORM_UNITY : res_ff[19:0];
   assign nmag     = prod_ff[47:0];
   assign trial    = {rem_ff[DEN_W-2:0], qn_ff[Q_W-1]};
   assign umag     = (ovf_ff || (qn_ff > CLIP_Q20)) ? CLIP_Q20 : qn_ff;
   assign delta    = neg_ff ? -26'(umag) : 26'(umag);
   assign csum     = 26'(coef_q_ff) + delta;

   always_comb begin
      coef_we = 1'b0;
      coef_wd = '0;
      if (clearing) begin
         coef_we = 1'b1;
      end else if (state_ff == ST_UAPP) begin
         coef_we = 1'b1;
         if (csum > 26'sd8388607) begin
            coef_wd = 24'sh7fffff;
         end else if (csum < -26'sd8388608) begin
            coef_wd = 24'sh800000;
         end else begin
            coef_wd = csum[23:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wptr_in      = wptr_ff;
      base_in      = base_ff;
      step_in      = step_ff;
      des_in       = des_ff;
      acc_in       = acc_ff;
      sumsq_in     = sumsq_ff;
      err_in       = err_ff;
      v_in         = v_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      den_in       = den_ff;
      se_in        = se_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      rem_in       = rem_ff;
      qn_in        = qn_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         step_in = csr_step_size;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLR: begin
            cnt_in = last ? '0 : cnt_ff + 1'b1;
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               base_in  = (wptr_ff == IDX_W'(TAPS - 1)) ? '0 : wptr_ff + 1'b1;
               wptr_in  = base_in;
               des_in   = req_desired_sample;
               acc_in   = '0;
               sumsq_in = '0;
               cnt_in   = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_M1;
         end
         ST_M1: begin
            state_in = ST_M2;
         end
         ST_M2: begin
            acc_in   = acc_ff + prod_ff[ACC_W-1:0];
            state_in = ST_M3;
         end
         ST_M3: begin
            sumsq_in = sumsq_ff + prod_ff[SQ_W-1:0];
            cnt_in   = last ? '0 : cnt_ff + 1'b1;
            state_in = last ? ST_ERR : ST_RD;
         end
         ST_ERR: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               if (er > 30'sd32767) begin
                  err_in = 16'sh7fff;
               end else if (er < -30'sd32768) begin
                  err_in = 16'sh8000;
               end else begin
                  err_in = er[15:0];
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = err_in;
               v_in         = sumsq_ff;
               res_in       = '0;
               bit_in       = SQ_BIT0;
               state_in     = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (v_ff >= sq_trial) begin
               v_in   = v_ff - sq_trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_SE;
            end
         end
         ST_SE: begin
            den_in   = DEN_W'({norm, 11'b0});
            state_in = ST_SE2;
         end
         ST_SE2: begin
            se_in    = prod_ff[32:0];
            cnt_in   = '0;
            state_in = ST_URD;
         end
         ST_URD: begin
            state_in = ST_UM;
         end
         ST_UM: begin
            neg_in   = se_ff[32] ^ dl_q_ff[15];
            state_in = ST_UCMP;
         end
         ST_UCMP: begin
            ovf_in   = ({1'b0, nmag} >= {den_ff, 17'b0});
            rem_in   = DEN_W'(nmag >> Q_W);
            qn_in    = nmag[Q_W-1:0];
            dcnt_in  = '0;
            state_in = ovf_in ? ST_UAPP : ST_UDIV;
         end
         ST_UDIV: begin
            if (trial >= den_ff) begin
               rem_in = trial - den_ff;
               qn_in  = {qn_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               qn_in  = {qn_ff[Q_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 5'(Q_W - 1)) begin
               state_in = ST_UAPP;
            end
         end
         ST_UAPP: begin
            cnt_in   = last ? '0 : cnt_ff + 1'b1;
            state_in = last ? ST_IDLE : ST_URD;
         end
         default: begin
            state_in = ST_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         wptr_ff      <= '0;
         base_ff      <= '0;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wptr_ff      <= wptr_in;
         base_ff      <= base_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      des_ff      <= des_in;
      acc_ff      <= acc_in;
      sumsq_ff    <= sumsq_in;
      prod_ff     <= mul_p;
      err_ff      <= err_in;
      v_ff        <= v_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      den_ff      <= den_in;
      se_ff       <= se_in;
      neg_ff      <= neg_in;
      ovf_ff      <= ovf_in;
      rem_ff      <= rem_in;
      qn_ff       <= qn_in;
      dcnt_ff     <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[dl_wa] <= dl_wd;
      end
      if (rd_en) begin
         dl_q_ff <= dl_mem[rd_phys];
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[cnt_ff] <= coef_wd;
      end
      if (rd_en) begin
         coef_q_ff <= coef_mem[cnt_ff];
      end
   end

`include "clipped_normalized_lms_filter_assert.svh"

   `CNLMS_ASSERT_NOW(a_sqrt_bit_onehot, state_ff == ST_SQRT, $onehot(bit_ff))
   `CNLMS_ASSERT_NOW(a_div_rem_below_den, state_ff == ST_UDIV, rem_ff < den_ff)
   `CNLMS_ASSERT_NEXT(a_rsp_after_err, !rsp_valid_ff && state_ff != ST_ERR, !rsp_valid_ff)

endmodule

FILE: bench/cnlms_checker.sv
module cnlms_checker #(
   parameter int TAPS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  cnlms_pkg::sample_type req_desired_sample,
   input  cnlms_pkg::sample_type req_reference_sample,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  cnlms_pkg::sample_type rsp_error_sample,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  cnlms_pkg::step_type   csr_step_size,
   output int                    mismatches,
   output int                    pending
);
   import cnlms_pkg::*;

   localparam longint COEF_HI = 64'sd8388607;
   localparam longint COEF_LO = -64'sd8388608;

   sample_type taps_line [TAPS];
   longint     weights [TAPS];
   step_type   mu;
   sample_type error_queue [$];

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic sample_type adapt(sample_type desired, sample_type reference);
      longint          acc;
      longint          diff;
      longint          err;
      longint          den;
      longint          num;
      longint          upd;
      longint          w;
      longint unsigned energy;
      acc    = 0;
      energy = 0;
      for (int i = 0; i + 1 < TAPS; i++) taps_line[i] = taps_line[i + 1];
      taps_line[TAPS - 1] = reference;
      for (int i = 0; i < TAPS; i++) begin
         acc    += weights[i] * longint'(taps_line[i]);
         energy += longint'(taps_line[i]) * longint'(taps_line[i]);
      end
      diff = longint'(desired) * 1048576 - acc;
      err  = (diff + 524288) >>> 20;
      if (err > 32767) err = 32767;
      if (err < -32768) err = -32768;
      den = (energy == 0) ? 64'sd32768 * 2048 : longint'(int_sqrt(energy)) * 2048;
      for (int i = 0; i < TAPS; i++) begin
         num = longint'({1'b0, mu}) * err * longint'(taps_line[i]);
         upd = num / den;
         if (upd > longint'(CLIP_Q20)) upd = longint'(CLIP_Q20);
         if (upd < -longint'(CLIP_Q20)) upd = -longint'(CLIP_Q20);
         w = weights[i] + upd;
         if (w > COEF_HI) w = COEF_HI;
         if (w < COEF_LO) w = COEF_LO;
         weights[i] = w;
      end
      return sample_type'(err);
   endfunction

   assign pending = error_queue.size();

   initial mismatches = 0;

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            taps_line[i] = '0;
            weights[i]   = 0;
         end
         mu = STEP_RESET;
         error_queue.delete();
      end else begin
         if (csr_valid && csr_ready) mu = csr_step_size;
         if (req_valid && !req_stall)
            error_queue.insert(error_queue.size(),
                               adapt(req_desired_sample, req_reference_sample));
         if (rsp_valid && !rsp_stall) begin
            if (error_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected item: error_sample %0d", rsp_error_sample);
            end else begin
               want = error_queue.pop_front();
               if (want !== rsp_error_sample) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("error_sample mismatch: expected %0d actual %0d",
                              want, rsp_error_sample);
               end
            end
         end
      end
   end
endmodule

FILE: bench/tb.sv
module tb;
   import cnlms_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   sample_type req_desired_sample;
   sample_type req_reference_sample;
   logic       rsp_valid;
   logic       rsp_stall;
   sample_type rsp_error_sample;
   logic       csr_valid;
   logic       csr_ready;
   step_type   csr_step_size;
   int         mismatches;
   int         pending;
   int         stall_left;
   sample_type history [8];

   clipped_normalized_lms_filter #(.TAPS(32)) DUT (.*);

   cnlms_checker #(.TAPS(32)) scoreboard (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(30, 300);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 4);
   endfunction

   // receiver stalls in bursts, with long free stretches too
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_left <= pick_gap();
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   task automatic send(input sample_type desired, input sample_type reference);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_desired_sample   <= desired;
      req_reference_sample <= reference;
      do @(posedge clock); while (req_stall);
      for (int i = 7; i > 0; i--) history[i] = history[i - 1];
      history[0] = reference;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (1000) @(posedge clock);
   endtask

   task automatic write_step(input step_type value);
      drain();
      csr_valid     <= 1'b1;
      csr_step_size <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      sample_type r;
      sample_type d;
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         r    = sample_type'($urandom);
         if (kind < 7) begin
            // unknown system: scaled, delayed reference plus small noise
            r = r >>> $urandom_range(0, 3);
            d = (history[2] >>> 1) - (history[5] >>> 2) + $signed(8'($urandom));
         end else if (kind < 9) begin
            d = sample_type'($urandom);
         end else begin
            r = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
            d = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
         end
         send(d, r);
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_desired_sample   = '0;
      req_reference_sample = '0;
      csr_valid            = 1'b0;
      csr_step_size        = '0;
      for (int i = 0; i < 8; i++) history[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all-zero delay line, then extremes at the reset step
      send(16'sh7fff, 16'sh0000);
      send(-16'sh8000, 16'sh0000);
      send(16'sh7fff, 16'sh7fff);
      send(-16'sh8000, -16'sh8000);
      send(16'sh0001, 16'shffff);
      send(16'sh0000, 16'sh0000);
      // largest step drives coefficients into clip and saturation
      write_step(16'hffff);
      for (int i = 0; i < 12; i++) send(16'sh7fff, 16'sh7fff);
      for (int i = 0; i < 5; i++) send(-16'sh8000, 16'sh7fff);

      random_phase(350);
      write_step(16'h0000);
      random_phase(250);
      write_step(16'd1311);
      random_phase(400);
      write_step(step_type'($urandom));
      random_phase(350);
      write_step(16'hffff);
      random_phase(380);

      drain();
      if (mismatches == 0 && pending == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("tb failed");
      $finish;
   end
endmodule
